FILE: rtl/core/wrwm_pkg.sv
// Shared types and constants for the water ripple wave map.
package wrwm_pkg;

  localparam int POS_W  = 7;
  localparam int WAVE_W = 32;
  localparam int DIM_W  = 8;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 3;

  localparam logic CMD_CELL = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] CFG_DAMP_SHIFT   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_HEIGHT_SHIFT = 3'd3;
  localparam logic [IDX_W-1:0] CFG_NB_DIST      = 3'd4;
  localparam logic [IDX_W-1:0] CFG_SEED_EN      = 3'd5;
  localparam logic [IDX_W-1:0] CFG_SEED_X       = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SEED_Y       = 3'd7;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 8'd128;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 8'd128;
  localparam logic [4:0]       RST_DAMP_SHIFT   = 5'd4;
  localparam logic [3:0]       RST_HEIGHT_SHIFT = 4'd2;
  localparam logic [2:0]       RST_NB_DIST      = 3'd1;

  typedef struct packed {
    logic             command;
    logic [POS_W-1:0] cell_x;
    logic [POS_W-1:0] cell_y;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]         source_x;
    logic [POS_W-1:0]         source_y;
    logic signed [WAVE_W-1:0] wave_value;
    logic                     active;
  } rsp_t;

endpackage

FILE: rtl/core/wrwm_ram.sv
// Generic single-port RAM with registered read.
module wrwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/water_ripple_wave_map.sv
// Top level of the two-bank water ripple wave map.
//
// Requests arrive on req/req_valid/req_stall; every request gives exactly one
// response on rsp/rsp_valid/rsp_stall. A transfer happens on a clock edge with
// valid high and stall low. The user must write registers through cfg_we/
// cfg_index/cfg_data only while the block is idle; the block does not enforce it.
// One request at a time, since each map bank has a single port:
//   process cell in the band: four reads of the previous map and three of the
//     current map, then update, damping and write-back; the next request is
//     accepted only once the response is in the output register.
//   cell outside the band: no map access; quiet cell: reads but no write-back.
//   end of frame: the banks swap and a seed step follows, or the response
//     comes directly when the frame is too small to swap.
// After reset both banks are swept to zero, all MAX_WIDTH*MAX_HEIGHT entries
// (16384 by default), one entry per cycle; req_stall stays high until then.
// A finished response waits in the output register while rsp_stall is high,
// and the next request is still taken; the one after that waits.
module water_ripple_wave_map #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int WAVE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  wrwm_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output wrwm_pkg::rsp_t                rsp,
  input  logic                          cfg_we,
  input  logic [wrwm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [wrwm_pkg::CFG_W-1:0]    cfg_data
);

  import wrwm_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SXW   = WAVE_BITS + 2;
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_SUM, S_WAVE,
    S_DAMP, S_WRITE, S_CLAMP, S_SEED, S_OUT
  } state_t;

  state_t state;

  logic [DIM_W-1:0] frame_width, frame_height;
  logic [4:0]       damping_shift;
  logic [3:0]       height_shift;
  logic [2:0]       neighbour_distance;
  logic             seed_enable;
  logic [POS_W-1:0] seed_x, seed_y;

  logic          bank_select;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic [POS_W-1:0] x_r, y_r;
  logic [AW-1:0]    here;
  logic             quiet;

  logic signed [WAVE_BITS-1:0] sum_r, cur_here, cur_d, cur_dw, wave_r;
  logic signed [SXW-1:0]       sx_r, sy_r;

  logic [POS_W-1:0]            res_x, res_y;
  logic signed [WAVE_BITS-1:0] res_wave;
  logic                        res_active;

  logic [DIM_W-1:0] eff_w, eff_h, big_dim;
  logic [AW-1:0]    here_next, off_d, off_dw, seed_addr;
  logic             in_band, eof_ok, seed_ok;

  logic                 prev_addr_sel;
  logic [AW-1:0]        prev_addr, cur_addr;
  logic                 cur_we;
  logic [WAVE_BITS-1:0] cur_wdata;
  logic [WAVE_BITS-1:0] rd0, rd1;
  logic                 we0, we1;
  logic [AW-1:0]        addr0, addr1;
  logic [WAVE_BITS-1:0] wdata0, wdata1;

  logic signed [WAVE_BITS-1:0] prev_rd, cur_rd, cur_d_f, cur_dw_f, amp;
  logic signed [SXW-1:0]       w_max, h_max;
  logic                        req_acc;

  assign eff_w = (32'(frame_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : frame_width;
  assign eff_h = (32'(frame_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height;
  assign big_dim = (eff_w > eff_h) ? eff_w : eff_h;

  assign here_next = AW'(AW'(req.cell_y) * ROW_STEP) + AW'(req.cell_x);
  assign off_d     = AW'(neighbour_distance);
  assign off_dw    = AW'(AW'(neighbour_distance) * ROW_STEP);
  assign seed_addr = AW'(AW'(seed_y) * ROW_STEP) + AW'(seed_x);

  assign in_band = !({4'b0, neighbour_distance} > req.cell_x)
                && !({4'b0, neighbour_distance} > req.cell_y)
                && !(9'({2'b0, req.cell_x}) + 9'(neighbour_distance) + 9'd2
                     > {1'b0, eff_w})
                && !(9'({2'b0, req.cell_y}) + 9'(neighbour_distance) + 9'd2
                     > {1'b0, eff_h});
  assign eof_ok  = ({1'b0, eff_w} > {5'b0, neighbour_distance, 1'b0})
                && ({1'b0, eff_h} > {5'b0, neighbour_distance, 1'b0});
  assign seed_ok = seed_enable && ({1'b0, seed_x} < eff_w) && ({1'b0, seed_y} < eff_h);
  assign amp     = WAVE_BITS'(WAVE_BITS'(big_dim) << height_shift);

  assign cur_d_f  = (neighbour_distance == 3'd0) ? wave_r : cur_d;
  assign cur_dw_f = (neighbour_distance == 3'd0) ? wave_r : cur_dw;
  assign w_max    = $signed(SXW'({1'b0, eff_w})) - SXW'(1);
  assign h_max    = $signed(SXW'({1'b0, eff_h})) - SXW'(1);

  assign req_stall = clearing || (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;

  // Port scheduling for the previous and current maps.
  always_comb begin
    prev_addr_sel = 1'b0;
    prev_addr     = here;
    cur_addr      = here;
    cur_we        = 1'b0;
    cur_wdata     = wave_r;
    case (state)
      S_RD0: begin
        prev_addr = here + off_d;
      end
      S_RD1: begin
        prev_addr = here - off_d;
        cur_addr  = here + off_d;
      end
      S_RD2: begin
        prev_addr = here + off_dw;
        cur_addr  = here + off_dw;
      end
      S_RD3: begin
        prev_addr = here - off_dw;
      end
      S_WRITE: begin
        cur_we = !quiet;
      end
      S_SEED: begin
        cur_addr  = seed_addr;
        cur_we    = seed_ok;
        cur_wdata = amp;
      end
      default: begin
        prev_addr_sel = 1'b1;
      end
    endcase
  end

  assign we0    = clearing || (bank_select && cur_we);
  assign we1    = clearing || (!bank_select && cur_we);
  assign addr0  = clearing ? clr_addr : (bank_select ? cur_addr : prev_addr);
  assign addr1  = clearing ? clr_addr : (bank_select ? prev_addr : cur_addr);
  assign wdata0 = clearing ? '0 : cur_wdata;
  assign wdata1 = clearing ? '0 : cur_wdata;

  assign prev_rd = bank_select ? rd1 : rd0;
  assign cur_rd  = bank_select ? rd0 : rd1;

  wrwm_ram #(.WIDTH(WAVE_BITS), .DEPTH(DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .addr  (addr0),
    .wdata (wdata0),
    .rdata (rd0)
  );

  wrwm_ram #(.WIDTH(WAVE_BITS), .DEPTH(DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .addr  (addr1),
    .wdata (wdata1),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      bank_select        <= 1'b0;
      clearing           <= 1'b1;
      clr_addr           <= '0;
      rsp_valid          <= 1'b0;
      frame_width        <= RST_FRAME_WIDTH;
      frame_height       <= RST_FRAME_HEIGHT;
      damping_shift      <= RST_DAMP_SHIFT;
      height_shift       <= RST_HEIGHT_SHIFT;
      neighbour_distance <= RST_NB_DIST;
      seed_enable        <= 1'b0;
      seed_x             <= '0;
      seed_y             <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width        <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height       <= cfg_data;
          CFG_DAMP_SHIFT:   damping_shift      <= cfg_data[4:0];
          CFG_HEIGHT_SHIFT: height_shift       <= cfg_data[3:0];
          CFG_NB_DIST:      neighbour_distance <= cfg_data[2:0];
          CFG_SEED_EN:      seed_enable        <= cfg_data[0];
          CFG_SEED_X:       seed_x             <= cfg_data[POS_W-1:0];
          CFG_SEED_Y:       seed_y             <= cfg_data[POS_W-1:0];
          default:          ;
        endcase
      end

      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            x_r        <= req.cell_x;
            y_r        <= req.cell_y;
            here       <= here_next;
            res_wave   <= '0;
            res_active <= 1'b0;
            if (req.command == CMD_EOF) begin
              res_x <= '0;
              res_y <= '0;
              if (eof_ok) begin
                bank_select <= !bank_select;
                state       <= S_SEED;
              end else begin
                state <= S_OUT;
              end
            end else begin
              res_x <= req.cell_x;
              res_y <= req.cell_y;
              state <= in_band ? S_RD0 : S_OUT;
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          sum_r    <= prev_rd;
          cur_here <= cur_rd;
          state    <= S_RD2;
        end
        S_RD2: begin
          sum_r <= sum_r + prev_rd;
          cur_d <= cur_rd;
          state <= S_RD3;
        end
        S_RD3: begin
          sum_r  <= sum_r + prev_rd;
          cur_dw <= cur_rd;
          state  <= S_SUM;
        end
        S_SUM: begin
          sum_r <= sum_r + prev_rd;
          state <= S_WAVE;
        end
        S_WAVE: begin
          wave_r <= (sum_r >>> 1) - cur_here;
          quiet  <= (sum_r == '0) && (cur_here == '0);
          state  <= S_DAMP;
        end
        S_DAMP: begin
          wave_r <= wave_r - (wave_r >>> damping_shift);
          state  <= S_WRITE;
        end
        S_WRITE: begin
          sx_r  <= $signed(SXW'({1'b0, x_r})) + SXW'(cur_d_f) - SXW'(wave_r);
          sy_r  <= $signed(SXW'({1'b0, y_r})) + SXW'(cur_dw_f) - SXW'(wave_r);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (!quiet) begin
            res_x      <= (sx_r < 0) ? '0 : ((sx_r > w_max) ? w_max[POS_W-1:0]
                                                            : sx_r[POS_W-1:0]);
            res_y      <= (sy_r < 0) ? '0 : ((sy_r > h_max) ? h_max[POS_W-1:0]
                                                            : sy_r[POS_W-1:0]);
            res_wave   <= wave_r;
            res_active <= 1'b1;
          end
          state <= S_OUT;
        end
        S_SEED: state <= S_OUT;
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.source_x   <= res_x;
            rsp.source_y   <= res_y;
            rsp.wave_value <= WAVE_W'(res_wave);
            rsp.active     <= res_active;
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bank_swap_on_eof: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !$stable(bank_select))
      |-> $past(req_valid && !req_stall && req.command == CMD_EOF))
    else $error("bank select changed without end of frame");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("response raised outside output state");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (state == S_IDLE && !rsp_valid))
    else $error("activity during map clearing");

  a_port_idle_sel: assert property (@(posedge clk) disable iff (rst)
    (cur_we && !clearing) |-> !prev_addr_sel || state == S_IDLE || state == S_OUT)
    else $error("map write outside update or seed");
`endif

endmodule

FILE: sim/water_ripple_wave_map_tb.sv
// Self-checking testbench for the two-bank water ripple wave map, scripted then random requests.
module water_ripple_wave_map_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wrwm_pkg::*;

  localparam int MAP_W          = 128;
  localparam int MAP_H          = 128;
  localparam int MAP_CELLS      = MAP_W * MAP_H;
  localparam int REQUEST_TARGET = 1500;

  typedef struct {
    bit               is_cfg;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    req_t             r;
    bit               typed;
    rsp_t             expected;
  } script_row_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  // predicted block state
  logic signed [WAVE_W-1:0] height_map [2][MAP_CELLS];
  logic                     bank_sel;
  logic [DIM_W-1:0]         frame_w, frame_h;
  logic [4:0]               damp_sh;
  logic [3:0]               amp_sh;
  logic [2:0]               nb_dist;
  logic                     seed_on;
  logic [POS_W-1:0]         seed_col, seed_row;

  rsp_t        expected_rsps[$];
  rsp_t        want_rsp;
  script_row_t script[$];
  int          mismatches = 0;
  int          sent       = 0;
  bit          idling     = 1'b1;

  water_ripple_wave_map i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("water_ripple_wave_map: mismatch");
    $finish;
  end

  function automatic rsp_t predict_response(req_t r);
    int w, h, d, x, y, here, big;
    logic signed [WAVE_W-1:0] sum, now_val, wave;
    longint sx, sy;
    logic p, c;
    rsp_t o;
    o = '0;
    w = (frame_w > MAP_W) ? MAP_W : int'(frame_w);
    h = (frame_h > MAP_H) ? MAP_H : int'(frame_h);
    d = nb_dist;
    x = r.cell_x;
    y = r.cell_y;
    p = bank_sel;
    c = ~bank_sel;
    if (r.command == CMD_EOF) begin
      if (w > 2 * d && h > 2 * d) begin
        bank_sel = ~bank_sel;
        if (seed_on && seed_col < w && seed_row < h) begin
          big = (w > h) ? w : h;
          height_map[~bank_sel][seed_row * MAP_W + seed_col] = WAVE_W'(big << amp_sh);
        end
      end
      return o;
    end
    o.source_x = r.cell_x;
    o.source_y = r.cell_y;
    if (x < d || y < d || x + d + 2 > w || y + d + 2 > h) return o;
    here = y * MAP_W + x;
    sum = height_map[p][here + d] + height_map[p][here - d]
        + height_map[p][here + d * MAP_W] + height_map[p][here - d * MAP_W];
    now_val = height_map[c][here];
    if (sum == 0 && now_val == 0) return o;
    wave = (sum >>> 1) - now_val;
    wave = wave - (wave >>> damp_sh);
    height_map[c][here] = wave;
    sx = longint'(x) + longint'(height_map[c][here + d]) - longint'(wave);
    sy = longint'(y) + longint'(height_map[c][here + d * MAP_W]) - longint'(wave);
    if (sx < 0) sx = 0;
    else if (sx > w - 1) sx = w - 1;
    if (sy < 0) sy = 0;
    else if (sy > h - 1) sy = h - 1;
    o.source_x   = sx[POS_W-1:0];
    o.source_y   = sy[POS_W-1:0];
    o.wave_value = wave;
    o.active     = 1'b1;
    return o;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      CFG_FRAME_WIDTH:  frame_w  = v;
      CFG_FRAME_HEIGHT: frame_h  = v;
      CFG_DAMP_SHIFT:   damp_sh  = v[4:0];
      CFG_HEIGHT_SHIFT: amp_sh   = v[3:0];
      CFG_NB_DIST:      nb_dist  = v[2:0];
      CFG_SEED_EN:      seed_on  = v[0];
      CFG_SEED_X:       seed_col = v[POS_W-1:0];
      CFG_SEED_Y:       seed_row = v[POS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic rsp_t quiet_rsp(int x, int y);
    rsp_t o;
    o = '0;
    o.source_x = POS_W'(x);
    o.source_y = POS_W'(y);
    return o;
  endfunction

  function automatic script_row_t cfg_row(logic [IDX_W-1:0] idx, int value);
    script_row_t s;
    s.is_cfg   = 1'b1;
    s.index    = idx;
    s.data     = CFG_W'(value);
    s.r        = '0;
    s.typed    = 1'b0;
    s.expected = '0;
    return s;
  endfunction

  function automatic script_row_t req_row(logic cmd, int x, int y, bit typed, rsp_t e);
    script_row_t s;
    s.is_cfg    = 1'b0;
    s.index     = '0;
    s.data      = '0;
    s.r.command = cmd;
    s.r.cell_x  = POS_W'(x);
    s.r.cell_y  = POS_W'(y);
    s.typed     = typed;
    s.expected  = e;
    return s;
  endfunction

  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(16, 4);
    if (roll < 80) return $urandom_range(128, 17);
    if (roll < 88) return 128;
    if (roll < 94) return $urandom_range(255, 129);
    return $urandom_range(3, 0);
  endfunction

  function automatic int pick_dist();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(3, 1);
    if (roll < 85) return 7;
    if (roll < 92) return 0;
    return $urandom_range(7, 0);
  endfunction

  function automatic int pick_damp();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return 0;
    if (roll < 30) return 31;
    if (roll < 90) return $urandom_range(8, 1);
    return $urandom_range(31, 0);
  endfunction

  function automatic int pick_seed(int extent);
    if (extent > 0 && $urandom_range(99) < 85) return $urandom_range(extent - 1, 0);
    return $urandom_range(127, 0);
  endfunction

  task automatic report_mismatch(string why, rsp_t want, rsp_t got);
    if (mismatches < 10)
      $display("wave map %s: want src=(%0d,%0d) wave=%0d active=%0b, got src=(%0d,%0d) wave=%0d active=%0b",
               why, want.source_x, want.source_y, $signed(want.wave_value), want.active,
               got.source_x, got.source_y, $signed(got.wave_value), got.active);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", '0, rsp);
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (rsp.source_x !== want_rsp.source_x || rsp.source_y !== want_rsp.source_y ||
            rsp.wave_value !== want_rsp.wave_value || rsp.active !== want_rsp.active)
          report_mismatch("response differs", want_rsp, rsp);
      end
    end
    rsp_stall <= idling && ($urandom_range(99) < 22);
  end

  task automatic send_request(req_t r, bit typed, rsp_t e);
    rsp_t pred;
    idling = !(sent >= 600 && sent < 900);
    if (idling && $urandom_range(99) < 22) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    pred = predict_response(r);
    expected_rsps.push_back(typed ? e : pred);
    sent++;
  endtask

  // drop req_valid and wait for all responses to be taken
  task automatic settle();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    apply_reg(idx, CFG_W'(value));
  endtask

  initial begin
    bit   in_cfg;
    bit   raster;
    int   w_cfg, h_cfg, d_cfg, ew, eh, hx, hy, cells, cx, cy, roll, frames;
    req_t r;

    for (int i = 0; i < MAP_CELLS; i++) begin
      height_map[0][i] = '0;
      height_map[1][i] = '0;
    end
    bank_sel = 1'b0;
    frame_w  = RST_FRAME_WIDTH;
    frame_h  = RST_FRAME_HEIGHT;
    damp_sh  = RST_DAMP_SHIFT;
    amp_sh   = RST_HEIGHT_SHIFT;
    nb_dist  = RST_NB_DIST;
    seed_on  = 1'b0;
    seed_col = '0;
    seed_row = '0;

    // reset state: all maps zero, no seed
    script.push_back(req_row(CMD_CELL, 0, 0, 1, quiet_rsp(0, 0)));
    script.push_back(req_row(CMD_CELL, 127, 127, 1, quiet_rsp(127, 127)));
    script.push_back(req_row(CMD_CELL, 64, 64, 1, quiet_rsp(64, 64)));
    script.push_back(req_row(CMD_CELL, 126, 1, 1, quiet_rsp(126, 1)));
    script.push_back(req_row(CMD_EOF, 127, 127, 1, '0));
    // small frame with a strong seed
    script.push_back(cfg_row(CFG_FRAME_WIDTH, 8));
    script.push_back(cfg_row(CFG_FRAME_HEIGHT, 8));
    script.push_back(cfg_row(CFG_DAMP_SHIFT, 31));
    script.push_back(cfg_row(CFG_HEIGHT_SHIFT, 15));
    script.push_back(cfg_row(CFG_SEED_EN, 1));
    script.push_back(cfg_row(CFG_SEED_X, 4));
    script.push_back(cfg_row(CFG_SEED_Y, 4));
    script.push_back(req_row(CMD_EOF, 0, 0, 1, '0));
    script.push_back(req_row(CMD_CELL, 4, 4, 0, '0));
    script.push_back(req_row(CMD_CELL, 3, 4, 0, '0));
    script.push_back(req_row(CMD_CELL, 5, 4, 0, '0));
    script.push_back(req_row(CMD_CELL, 4, 3, 0, '0));
    script.push_back(req_row(CMD_CELL, 4, 5, 0, '0));
    script.push_back(req_row(CMD_EOF, 0, 0, 1, '0));
    script.push_back(req_row(CMD_CELL, 4, 4, 0, '0));
    script.push_back(req_row(CMD_CELL, 5, 5, 0, '0));
    script.push_back(req_row(CMD_CELL, 1, 1, 0, '0));
    script.push_back(req_row(CMD_CELL, 6, 6, 1, quiet_rsp(6, 6)));
    // seed off the frame, damping shift 0 (full damping)
    script.push_back(cfg_row(CFG_SEED_X, 127));
    script.push_back(cfg_row(CFG_DAMP_SHIFT, 0));
    script.push_back(req_row(CMD_EOF, 0, 0, 1, '0));
    script.push_back(req_row(CMD_CELL, 4, 4, 0, '0));
    // frame too small for the neighbour distance
    script.push_back(cfg_row(CFG_NB_DIST, 4));
    script.push_back(req_row(CMD_EOF, 0, 0, 1, '0));
    script.push_back(req_row(CMD_CELL, 4, 4, 1, quiet_rsp(4, 4)));
    // oversized frame, largest neighbour distance
    script.push_back(cfg_row(CFG_FRAME_WIDTH, 200));
    script.push_back(cfg_row(CFG_FRAME_HEIGHT, 255));
    script.push_back(cfg_row(CFG_NB_DIST, 7));
    script.push_back(cfg_row(CFG_SEED_X, 127));
    script.push_back(cfg_row(CFG_SEED_Y, 0));
    script.push_back(cfg_row(CFG_HEIGHT_SHIFT, 0));
    script.push_back(cfg_row(CFG_DAMP_SHIFT, 4));
    script.push_back(req_row(CMD_EOF, 0, 0, 1, '0));
    script.push_back(req_row(CMD_CELL, 7, 7, 0, '0));
    script.push_back(req_row(CMD_CELL, 119, 119, 0, '0));
    script.push_back(req_row(CMD_CELL, 120, 7, 1, quiet_rsp(120, 7)));
    script.push_back(req_row(CMD_EOF, 127, 0, 1, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    in_cfg = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_reg(script[i].index, script[i].data);
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_request(script[i].r, script[i].typed, script[i].expected);
      end
    end

    while (sent < REQUEST_TARGET) begin
      settle();
      w_cfg = pick_dim();
      h_cfg = pick_dim();
      d_cfg = pick_dist();
      ew    = (w_cfg > MAP_W) ? MAP_W : w_cfg;
      eh    = (h_cfg > MAP_H) ? MAP_H : h_cfg;
      write_reg(CFG_FRAME_WIDTH, w_cfg);
      write_reg(CFG_FRAME_HEIGHT, h_cfg);
      write_reg(CFG_DAMP_SHIFT, pick_damp());
      write_reg(CFG_HEIGHT_SHIFT, $urandom_range(15, 0));
      write_reg(CFG_NB_DIST, d_cfg);
      write_reg(CFG_SEED_EN, ($urandom_range(99) < 85) ? 1 : 0);
      write_reg(CFG_SEED_X, pick_seed(ew));
      write_reg(CFG_SEED_Y, pick_seed(eh));
      cfg_we <= 1'b0;
      hx     = ew - d_cfg - 2;
      hy     = eh - d_cfg - 2;
      frames = $urandom_range(5, 2);
      repeat (frames) begin
        r.command = CMD_EOF;
        r.cell_x  = $urandom_range(127, 0);
        r.cell_y  = $urandom_range(127, 0);
        send_request(r, 1'b0, '0);
        cells  = $urandom_range(40, 8);
        raster = $urandom_range(1, 0);
        cx     = d_cfg;
        cy     = d_cfg;
        for (int k = 0; k < cells; k++) begin
          roll = $urandom_range(99);
          if (roll < 6 || hx < d_cfg || hy < d_cfg) begin
            r.command = CMD_CELL;
            r.cell_x  = $urandom_range(127, 0);
            r.cell_y  = $urandom_range(127, 0);
          end else if (roll < 9) begin
            r.command = CMD_EOF;
            r.cell_x  = $urandom_range(127, 0);
            r.cell_y  = $urandom_range(127, 0);
          end else if (raster) begin
            r.command = CMD_CELL;
            r.cell_x  = POS_W'(cx);
            r.cell_y  = POS_W'(cy);
            cx++;
            if (cx > hx) begin
              cx = d_cfg;
              cy = (cy >= hy) ? d_cfg : cy + 1;
            end
          end else begin
            r.command = CMD_CELL;
            r.cell_x  = $urandom_range(hx, d_cfg);
            r.cell_y  = $urandom_range(hy, d_cfg);
          end
          send_request(r, 1'b0, '0);
        end
      end
    end

    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("water_ripple_wave_map: match");
    end else begin
      $display("water_ripple_wave_map: mismatch");
    end
    $finish;
  end

endmodule
